[design/tspf_pkg.sv]
// Shared types and constants for the transport stream PID payload filter.
// No dependencies.
package tspf_pkg;

	localparam logic [7:0] PACKET_BYTES = 8'd188;
	localparam logic [7:0] HDR_PID_HI   = 8'd1;
	localparam logic [7:0] HDR_PID_LO   = 8'd2;
	localparam logic [7:0] HDR_CTRL     = 8'd3;
	localparam logic [7:0] HDR_BYTES    = 8'd4;
	localparam logic [8:0] AF_BASE      = 9'd5;

	localparam logic [12:0] TARGET_PID_RST    = 13'd0;
	localparam logic [7:0]  UNIT_LEN_RST      = 8'd188;
	localparam logic [6:0]  PACKET_OFFSET_RST = 7'd0;

	typedef enum logic [1:0] {
		CFG_TARGET_PID    = 2'd0,
		CFG_UNIT_LEN      = 2'd1,
		CFG_PACKET_OFFSET = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic [12:0] target_pid;
		logic [7:0]  unit_len;
		logic [6:0]  packet_offset;
	} cfg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       rearm;
	} item_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       unit_start;
		logic       last_of_packet;
	} result_t;

endpackage

[design/ts_pid_payload_filter.sv]
// Transport stream PID payload filter, top level.
// Path: an accepted byte is held in the stage 1 register, then parsed into the output register.
// Throughput: one byte per cycle while result_stall does not hold the output register.
// Reset: asynchronous, clears parse state, capture arming and both valid flags;
// registers return to target_pid 0, unit_len 188, packet_offset 0. Depends on tspf_pkg.
module ts_pid_payload_filter (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  tspf_pkg::item_t     item_data,
	output logic                result_valid,
	input  logic                result_stall,
	output tspf_pkg::result_t   result_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [12:0]         cfg_data
);
	import tspf_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    s1_valid_q;
	logic    adv;
	logic    res_valid;
	result_t res;
	result_t result_q;
	logic    result_valid_q;

	assign cfg_ready = 1'b1;

	tspf_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign adv        = s1_valid_q && (!result_valid_q || !result_stall);
	assign item_stall = s1_valid_q && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (item_valid && !item_stall) begin
			s1_valid_q <= 1'b1;
		end else if (adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item_data;
		end
	end

	tspf_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.item      (item_s1),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv) begin
			result_valid_q <= res_valid;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_q <= res;
		end
	end

	assign result_valid = result_valid_q;
	assign result_data  = result_q;

`ifndef SYNTH
	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && result_valid && result_stall |-> item_stall)
		else $error("input taken while stage 1 is blocked");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && !s1_valid_q |=> !result_valid)
		else $error("result repeated after transaction");

	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> s1_valid_q)
		else $error("accepted byte lost before parse");
`endif

endmodule

[design/tspf_cfg.sv]
// Configuration register file of the PID payload filter.
// Depends on tspf_pkg.
module tspf_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [1:0]          wr_index,
	input  logic [12:0]         wr_data,
	output tspf_pkg::cfg_t      cfg
);
	import tspf_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_pid    <= TARGET_PID_RST;
			cfg_q.unit_len      <= UNIT_LEN_RST;
			cfg_q.packet_offset <= PACKET_OFFSET_RST;
		end else if (wr_en) begin
			case (cfg_index_t'(wr_index))
				CFG_TARGET_PID:    cfg_q.target_pid    <= wr_data;
				CFG_UNIT_LEN:      cfg_q.unit_len      <= wr_data[7:0];
				CFG_PACKET_OFFSET: cfg_q.packet_offset <= wr_data[6:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[design/tspf_parse.sv]
// Packet header parser and payload selector; one byte per enabled cycle.
// Depends on tspf_pkg.
module tspf_parse (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  tspf_pkg::item_t     item,
	input  tspf_pkg::cfg_t      cfg,
	output logic                res_valid,
	output tspf_pkg::result_t   res
);
	import tspf_pkg::*;

	logic [7:0] pos_q,   pos_d;
	logic [4:0] pid_hi_q, pid_hi_d;
	logic       match_q, match_d;
	logic       start_q, start_d;
	logic [1:0] fc_q,    fc_d;
	logic [7:0] skip_q,  skip_d;
	logic       armed_q, armed_d;
	logic       pend_q,  pend_d;

	logic [8:0] diff;
	logic [7:0] k;
	logic       in_pkt;
	logic       pid_eq;
	logic [7:0] skip_v;
	logic [8:0] first;
	logic [8:0] pos_inc;

	always_comb begin
		pos_d    = pos_q;
		pid_hi_d = pid_hi_q;
		match_d  = match_q;
		start_d  = start_q;
		fc_d     = fc_q;
		skip_d   = skip_q;
		armed_d  = armed_q;
		pend_d   = pend_q;
		res_valid = 1'b0;
		res.payload_byte   = item.data_byte;
		res.unit_start     = 1'b0;
		res.last_of_packet = 1'b0;

		diff   = {1'b0, pos_q} - {2'b00, cfg.packet_offset};
		k      = diff[7:0];
		in_pkt = !diff[8] && (k < PACKET_BYTES);
		pid_eq = ({pid_hi_q, item.data_byte} == cfg.target_pid);
		skip_v = skip_q;
		first  = {1'b0, HDR_BYTES};

		if (item.rearm) begin
			armed_d = 1'b0;
			pend_d  = 1'b0;
		end

		if (in_pkt) begin
			if (k == HDR_PID_HI) begin
				pid_hi_d = item.data_byte[4:0];
				start_d  = item.data_byte[6];
			end else if (k == HDR_PID_LO) begin
				match_d = pid_eq;
				pend_d  = pid_eq && start_q;
				if (pid_eq && start_q) begin
					armed_d = 1'b1;
				end
			end else if (k == HDR_CTRL) begin
				fc_d = item.data_byte[5:4];
			end else if (k >= HDR_BYTES) begin
				if (fc_q[1]) begin
					if (k == HDR_BYTES) begin
						skip_d = item.data_byte;
						skip_v = item.data_byte;
					end
					first = AF_BASE + {1'b0, skip_v};
				end
				if (match_q && armed_d && fc_q[0] && ({1'b0, k} >= first)) begin
					res_valid          = 1'b1;
					res.unit_start     = pend_d;
					res.last_of_packet = (k == PACKET_BYTES - 8'd1);
					pend_d             = 1'b0;
				end
			end
		end

		pos_inc = {1'b0, pos_q} + 9'd1;
		if (pos_inc >= {1'b0, cfg.unit_len}) begin
			pos_d = 8'd0;
		end else begin
			pos_d = pos_inc[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			pid_hi_q <= '0;
			match_q  <= 1'b0;
			start_q  <= 1'b0;
			fc_q     <= '0;
			skip_q   <= '0;
			armed_q  <= 1'b0;
			pend_q   <= 1'b0;
		end else if (en) begin
			pos_q    <= pos_d;
			pid_hi_q <= pid_hi_d;
			match_q  <= match_d;
			start_q  <= start_d;
			fc_q     <= fc_d;
			skip_q   <= skip_d;
			armed_q  <= armed_d;
			pend_q   <= pend_d;
		end
	end

endmodule
